/* src/crc8_checked_frame_unpacker_top_macros.svh */
`ifndef CRC8_CHECKED_FRAME_UNPACKER_TOP_MACROS_SVH
`define CRC8_CHECKED_FRAME_UNPACKER_TOP_MACROS_SVH

// same-cycle implication on clk_i, off during reset
`define CFU_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error(msg);

// next-cycle implication on clk_i, off during reset
`define CFU_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error(msg);

`endif

/* src/crc8cfu_pkg.sv */
`default_nettype none

package crc8cfu_pkg;

  localparam int unsigned FrameBytes = 30;
  localparam int unsigned PosW       = 6;
  localparam int unsigned AddrW      = $clog2(FrameBytes);

  localparam logic [7:0] CrcPoly = 8'hD5;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [4:0]       field_id_t;

  localparam pos_t LastPos   = PosW'(FrameBytes - 1);
  localparam pos_t CrcPos    = PosW'(FrameBytes - 2);
  localparam pos_t CrcEndPos = PosW'(FrameBytes - 3);

  localparam field_id_t FieldThrust0 = 5'd0;
  localparam field_id_t FieldCtrl0   = 5'd6;
  localparam field_id_t FieldTune0   = 5'd11;
  localparam field_id_t FieldPivot0  = 5'd14;
  localparam field_id_t FieldLast    = 5'd16;

  localparam logic [5:0] ThrustBase = 6'd2;
  localparam logic [5:0] CtrlBase   = 6'd14;
  localparam logic [5:0] TuneBase   = 6'd19;
  localparam logic [5:0] PivotBase  = 6'd25;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    field_id_t          field_id;
    logic signed [15:0] field_value;
    logic               crc_ok;
    logic               last_result;
  } out_beat_t;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic done;
    logic ok;
  } rx_done_t;

  typedef struct packed {
    logic busy;
    logic out_pending;
  } emit_stat_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int n = 0; n < 8; n++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/crc8cfu_ram.sv */
`default_nettype none

module crc8cfu_ram #(
  parameter int unsigned Depth = 30,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

/* src/crc8cfu_rx.sv */
`default_nettype none

module crc8cfu_rx (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire crc8cfu_pkg::in_beat_t beat_i,
  output crc8cfu_pkg::ram_wr_t       wr_o,
  output crc8cfu_pkg::rx_done_t      done_o,
  output logic                       at_last_o
);

  import crc8cfu_pkg::*;

  pos_t       pos_q, pos_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] exp_q, exp_d;
  logic       in_frame;

  assign in_frame = (pos_q != '0) && (pos_q <= LastPos);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    exp_d = exp_q;
    if (accept_i) begin
      if (beat_i.frame_start) begin
        pos_d = PosW'(1);
        crc_d = '0;
      end else if (!in_frame) begin
        pos_d = '0;
      end else begin
        if (pos_q <= CrcEndPos) begin
          crc_d = crc8_update(crc_q, beat_i.byte_value);
        end
        if (pos_q == CrcPos) begin
          exp_d = beat_i.byte_value;
        end
        if (pos_q == LastPos) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_comb begin
    wr_o.en     = accept_i && (beat_i.frame_start || in_frame);
    wr_o.addr   = beat_i.frame_start ? '0 : pos_q[AddrW-1:0];
    wr_o.data   = beat_i.byte_value;
    done_o.done = accept_i && !beat_i.frame_start && (pos_q == LastPos);
    done_o.ok   = (crc_q == exp_q);
  end

  assign at_last_o = (pos_q == LastPos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
      exp_q <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      exp_q <= exp_d;
    end
  end

endmodule

`default_nettype wire

/* src/crc8cfu_emit.sv */
`default_nettype none

module crc8cfu_emit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire crc8cfu_pkg::rx_done_t done_i,
  input  wire logic [7:0]            rdata_a_i,
  input  wire logic [7:0]            rdata_b_i,
  output crc8cfu_pkg::addr_t         raddr_a_o,
  output crc8cfu_pkg::addr_t         raddr_b_o,
  output crc8cfu_pkg::emit_stat_t    stat_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output crc8cfu_pkg::out_beat_t     out_beat_o
);

  import crc8cfu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_HOLD
  } state_e;

  state_e     state_q;
  field_id_t  k_q;
  logic       out_valid_q;
  out_beat_t  out_beat_q;
  logic [5:0] kx;
  logic [5:0] addr_a, addr_b;
  logic [15:0] value;

  assign kx = {1'b0, k_q};

  always_comb begin
    addr_a = '0;
    addr_b = '0;
    case (k_q) inside
      [FieldThrust0:FieldCtrl0-5'd1]: begin
        addr_a = ThrustBase + (kx << 1);
        addr_b = ThrustBase + (kx << 1) + 6'd1;
      end
      [FieldCtrl0:FieldTune0-5'd1]: begin
        addr_a = CtrlBase + (kx - 6'(FieldCtrl0));
        addr_b = addr_a;
      end
      [FieldTune0:FieldPivot0-5'd1]: begin
        addr_a = TuneBase + ((kx - 6'(FieldTune0)) << 1);
        addr_b = TuneBase + ((kx - 6'(FieldTune0)) << 1) + 6'd1;
      end
      [FieldPivot0:FieldLast]: begin
        addr_a = PivotBase + (kx - 6'(FieldPivot0));
        addr_b = addr_a;
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  assign raddr_a_o = AddrW'(addr_a);
  assign raddr_b_o = AddrW'(addr_b);

  always_comb begin
    case (k_q) inside
      [FieldThrust0:FieldCtrl0-5'd1]: value = {rdata_b_i, rdata_a_i};
      [FieldCtrl0:FieldTune0-5'd1]:   value = {8'h00, rdata_a_i};
      [FieldTune0:FieldPivot0-5'd1]:  value = {rdata_a_i, rdata_b_i};
      [FieldPivot0:FieldLast]:        value = {{8{rdata_a_i[7]}}, rdata_a_i};
      default:                        value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_beat_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (done_i.done) begin
            if (done_i.ok) begin
              k_q     <= FieldThrust0;
              state_q <= ST_READ;
            end else begin
              out_valid_q             <= 1'b1;
              out_beat_q.field_id     <= FieldThrust0;
              out_beat_q.field_value  <= '0;
              out_beat_q.crc_ok       <= 1'b0;
              out_beat_q.last_result  <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          out_valid_q             <= 1'b1;
          out_beat_q.field_id     <= k_q;
          out_beat_q.field_value  <= value;
          out_beat_q.crc_ok       <= 1'b1;
          out_beat_q.last_result  <= (k_q == FieldLast);
          state_q                 <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (k_q == FieldLast) begin
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + 5'd1;
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_beat_o         = out_beat_q;
  assign stat_o.busy        = (state_q != ST_IDLE);
  assign stat_o.out_pending = out_valid_q;

endmodule

`default_nettype wire

/* src/crc8_checked_frame_unpacker_top.sv */
// CRC-8 checked frame unpacker.
// Input channel: one frame byte per beat (in_valid_i / in_stall_o, in_beat_i);
// frame_start marks byte zero and always restarts the frame.
// Bytes are written to a single frame memory; the LSB-first CRC-8 over bytes
// 1..N-3 is compared with byte N-2 when byte N-1 arrives.
// Output channel: result beats (out_valid_o / out_stall_i, out_beat_o).
// A mismatch gives one failure beat on the cycle after the last byte.
// A match gives 17 field beats. For each field the emitter passes through a
// memory read state, a format state that loads the output register, and a
// hold state that keeps each beat valid until the output channel takes it.
// Bytes are taken one per cycle inside a frame; in_stall_o is high during a
// field burst, and on the last byte of a frame while a result is still waiting.
// A stalled failure beat waits in the output register; other bytes flow on.
// Reset clears the byte position, CRC and output valid; the block then waits
// for a frame start. The frame memory itself needs no clearing.
`default_nettype none
`include "crc8_checked_frame_unpacker_top_macros.svh"

module crc8_checked_frame_unpacker_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire crc8cfu_pkg::in_beat_t in_beat_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output crc8cfu_pkg::out_beat_t     out_beat_o
);

  import crc8cfu_pkg::*;

  logic       in_accept;
  ram_wr_t    wr;
  rx_done_t   rx_done;
  emit_stat_t emit_stat;
  logic       at_last;
  addr_t      raddr_a, raddr_b;
  logic [7:0] rdata_a, rdata_b;

  assign in_stall_o = emit_stat.busy || (emit_stat.out_pending && at_last);
  assign in_accept  = in_valid_i && !in_stall_o;

  crc8cfu_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .beat_i    (in_beat_i),
    .wr_o      (wr),
    .done_o    (rx_done),
    .at_last_o (at_last)
  );

  crc8cfu_ram #(
    .Depth (FrameBytes),
    .Width (8),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr.en),
    .waddr_i   (wr.addr),
    .wdata_i   (wr.data),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  crc8cfu_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (rx_done),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .stat_o      (emit_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  `CFU_ASSERT_IMP(a_done_when_free, rx_done.done, !emit_stat.busy && !out_valid_o, "frame end while output busy")
  `CFU_ASSERT_IMP(a_busy_stalls, emit_stat.busy, in_stall_o, "byte accepted during burst")
  `CFU_ASSERT_IMP(a_fail_beat, out_valid_o && !out_beat_o.crc_ok, out_beat_o.last_result && (out_beat_o.field_id == FieldThrust0), "bad failure beat")
  `CFU_ASSERT_NXT(a_last_ends, out_valid_o && out_beat_o.last_result && !out_stall_i, !emit_stat.busy && !out_valid_o, "burst continues after last beat")

endmodule

`default_nettype wire
